// File: src/lzs_pkg.sv
package lzs_pkg;

  // Widths of the descriptor fields on the result channel
  localparam int unsigned POS_OUT_W = 32;
  localparam int unsigned UNP_W     = 40;
  localparam int unsigned TOTAL_W   = 13;

  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_INVALID   = 2'd2,
    ST_LIMIT     = 2'd3
  } lzs_status_e;

  typedef struct packed {
    logic                 block_valid;
    logic [POS_OUT_W-1:0] pack_offset;
    logic [POS_OUT_W-1:0] pack_length;
    logic [UNP_W-1:0]     unp_offset;
    logic [UNP_W-1:0]     unpack_length;
    logic                 stream_done;
    logic [TOTAL_W-1:0]   block_total;
    logic [UNP_W-1:0]     unpack_total;
    lzs_status_e          parse_status;
  } lzs_result_t;

endpackage

// File: src/lzs_ifs.sv
interface lzs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source(output valid, output data_byte, output final_byte, input ready);
  modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface lzs_out_if;
  logic                             valid;
  logic                             ready;
  logic                             block_valid;
  logic [lzs_pkg::POS_OUT_W-1:0]    pack_offset;
  logic [lzs_pkg::POS_OUT_W-1:0]    pack_length;
  logic [lzs_pkg::UNP_W-1:0]        unp_offset;
  logic [lzs_pkg::UNP_W-1:0]        unpack_length;
  logic                             stream_done;
  logic [lzs_pkg::TOTAL_W-1:0]      block_total;
  logic [lzs_pkg::UNP_W-1:0]        unpack_total;
  logic [1:0]                       parse_status;

  modport source(
    output valid, output block_valid, output pack_offset, output pack_length,
    output unp_offset, output unpack_length, output stream_done,
    output block_total, output unpack_total, output parse_status,
    input ready
  );
  modport sink(
    input valid, input block_valid, input pack_offset, input pack_length,
    input unp_offset, input unpack_length, input stream_done,
    input block_total, input unpack_total, input parse_status,
    output ready
  );
endinterface

// File: src/lzma2_chunk_block_splitter.sv
// Path: a request is taken into the input register and parsed; its result is loaded
//   into the result register when free (input register, parse logic, result register).
// Throughput: one byte per cycle unless the sink stalls a result; one parse update per byte.
// Reset (rst_ni low, asynchronous): parse state and the valid flags of the input and
//   result registers cleared; the byte after a final byte starts a new payload at offset 0.
module lzma2_chunk_block_splitter #(
  parameter int unsigned MAX_BLOCKS    = 4096,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzs_in_if.sink     in_i,
  lzs_out_if.source  out_o
);

  // Input register: holds one byte request in front of the parser.
  logic                 in_vq;
  logic [7:0]           in_byte_q;
  logic                 in_fin_q;

  // Result register: holds one finished result until the sink takes it.
  logic                 out_vq;
  lzs_pkg::lzs_result_t out_q;

  logic                 has_result;
  lzs_pkg::lzs_result_t result;
  logic                 out_free;
  logic                 advance;

  // Advance the held byte when its result has a free slot, or when it yields none
  // (skipped packed data and header bytes, unless final, never wait on the sink).
  assign out_free = !out_vq || out_o.ready;
  assign advance  = in_vq && (out_free || !has_result);
  assign in_i.ready = !in_vq || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  // Payload needs no reset; it only loads with a new request.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_fin_q  <= in_i.final_byte;
    end
  end

  // Chunk walk, block close and totals for the held byte.
  lzs_parser #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (advance),
    .data_byte_i (in_byte_q),
    .final_byte_i(in_fin_q),
    .has_result_o(has_result),
    .result_o    (result)
  );

  // Load a new result when one is produced; drop the valid when the old one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (out_free) begin
      out_vq <= advance && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && has_result) begin
      out_q <= result;
    end
  end

  assign out_o.valid         = out_vq;
  assign out_o.block_valid   = out_q.block_valid;
  assign out_o.pack_offset   = out_q.pack_offset;
  assign out_o.pack_length   = out_q.pack_length;
  assign out_o.unp_offset    = out_q.unp_offset;
  assign out_o.unpack_length = out_q.unpack_length;
  assign out_o.stream_done   = out_q.stream_done;
  assign out_o.block_total   = out_q.block_total;
  assign out_o.unpack_total  = out_q.unpack_total;
  assign out_o.parse_status  = out_q.parse_status;

endmodule

// File: src/lzs_parser.sv
module lzs_parser #(
  parameter int unsigned MAX_BLOCKS    = 4096,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  output logic                 has_result_o,
  output lzs_pkg::lzs_result_t result_o
);

  localparam int unsigned PW   = POSITION_BITS;
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned UW   = lzs_pkg::UNP_W;
  localparam int unsigned OW   = lzs_pkg::POS_OUT_W;
  localparam int unsigned TW   = lzs_pkg::TOTAL_W;

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;

  localparam logic [7:0] CTRL_PAD       = 8'h00;
  localparam logic [7:0] CTRL_STORED_DR = 8'h01;
  localparam logic [7:0] CTRL_STORED    = 8'h02;
  localparam logic [7:0] CTRL_LZMA_MIN  = 8'h80;
  localparam logic [7:0] CTRL_PROPS_MIN = 8'hC0;
  localparam logic [7:0] CTRL_DR_MIN    = 8'hE0;
  localparam logic [7:0] UNP_HI_MASK    = 8'h1F;

  localparam logic [2:0] HL_STORED = 3'd3;
  localparam logic [2:0] HL_LZMA   = 3'd5;
  localparam logic [2:0] HL_PROPS  = 3'd6;

  localparam logic [CNTW-1:0] BLK_LIMIT = CNTW'(MAX_BLOCKS);
  localparam logic [UW-1:0]   UNP_MAX   = '1;

  function automatic logic [UW-1:0] sat_add(input logic [UW-1:0] a, input logic [UW-1:0] b);
    logic [UW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UW] ? UNP_MAX : s[UW-1:0];
  endfunction

  logic [1:0]              phase_q, phase_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic [PW-1:0]           next_ctrl_q, next_ctrl_d;
  logic [PW-1:0]           blk_start_q, blk_start_d;
  logic [PW-1:0]           ctrl_pos_q, ctrl_pos_d;
  logic [7:0]              ctrl_val_q, ctrl_val_d;
  logic [2:0]              hdr_idx_q, hdr_idx_d;
  logic [20:0]             chunk_unp_q, chunk_unp_d;
  logic [15:0]             chunk_pk_q, chunk_pk_d;
  logic [UW-1:0]           run_unp_q, run_unp_d;
  logic [UW-1:0]           blk_sum_q, blk_sum_d;
  logic [CNTW-1:0]         blocks_q, blocks_d;
  lzs_pkg::lzs_status_e    stop_q, stop_d;

  logic                    at_ctrl, at_limit, dict_reset, chunk_ok, emit1, emit2, emit;
  logic [PW-1:0]           len1, len2, end_pos, len_sel;
  logic [2:0]              idx_inc, hl;
  logic [20:0]             unp_new;
  logic [15:0]             pk_new;
  logic [21:0]             unp_plus, pk_plus;
  logic                    hdr_done;
  logic [1:0]              phase_n;
  logic [PW-1:0]           next_ctrl_n, ctrl_pos_n;
  logic [UW-1:0]           blk_sum_n, run_new;
  lzs_pkg::lzs_status_e    stop_n;
  logic [CNTW-1:0]         blocks_after;
  logic [PW+OW-1:0]        off_ext, len_ext;
  logic [CNTW+TW-1:0]      tot_ext;

  // Control byte and header decode
  assign at_ctrl    = (phase_q == PH_CTRL) && (pos_q == next_ctrl_q);
  assign at_limit   = (blocks_q >= BLK_LIMIT);
  assign dict_reset = (data_byte_i == CTRL_STORED_DR) || (data_byte_i >= CTRL_DR_MIN);
  assign chunk_ok   = (data_byte_i == CTRL_STORED_DR) || (data_byte_i == CTRL_STORED) ||
                      (data_byte_i >= CTRL_LZMA_MIN);

  assign len1  = pos_q - blk_start_q;
  assign emit1 = at_ctrl && !at_limit && (data_byte_i != CTRL_PAD) && dict_reset &&
                 (len1 != '0);

  assign idx_inc = hdr_idx_q + 3'd1;
  assign hl      = (ctrl_val_q < CTRL_LZMA_MIN)  ? HL_STORED :
                   (ctrl_val_q >= CTRL_PROPS_MIN) ? HL_PROPS : HL_LZMA;

  always_comb begin
    unp_new = chunk_unp_q;
    pk_new  = chunk_pk_q;
    case (idx_inc)
      3'd1:    unp_new = chunk_unp_q | {5'b0, data_byte_i, 8'b0};
      3'd2:    unp_new = chunk_unp_q | {13'b0, data_byte_i};
      3'd3:    pk_new  = {data_byte_i, 8'b0};
      3'd4:    pk_new  = chunk_pk_q | {8'b0, data_byte_i};
      default: ;
    endcase
  end

  assign hdr_done = (phase_q == PH_HDR) && (idx_inc >= (hl - 3'd1));
  assign unp_plus = {1'b0, unp_new} + 22'd1;
  assign pk_plus  = (hl == HL_STORED) ? unp_plus : ({6'b0, pk_new} + 22'd1);

  // First part of the step: everything but the final-byte close
  always_comb begin
    phase_n     = phase_q;
    next_ctrl_n = next_ctrl_q;
    ctrl_pos_n  = ctrl_pos_q;
    blk_sum_n   = blk_sum_q;
    stop_n      = stop_q;
    ctrl_val_d  = ctrl_val_q;
    hdr_idx_d   = hdr_idx_q;
    chunk_unp_d = chunk_unp_q;
    chunk_pk_d  = chunk_pk_q;
    unique case (phase_q)
      PH_CTRL: begin
        if (at_ctrl) begin
          ctrl_pos_n = pos_q;
          if (at_limit) begin
            phase_n = PH_STOP;
            stop_n  = lzs_pkg::ST_LIMIT;
          end else if (data_byte_i == CTRL_PAD) begin
            next_ctrl_n = pos_q + PW'(1);
          end else if (chunk_ok) begin
            ctrl_val_d  = data_byte_i;
            hdr_idx_d   = 3'd0;
            chunk_unp_d = (data_byte_i >= CTRL_LZMA_MIN) ?
                          {data_byte_i[4:0] & UNP_HI_MASK[4:0], 16'b0} : 21'b0;
            chunk_pk_d  = 16'b0;
            phase_n     = PH_HDR;
          end else begin
            phase_n = PH_STOP;
            stop_n  = lzs_pkg::ST_INVALID;
          end
        end
      end
      PH_HDR: begin
        chunk_unp_d = unp_new;
        chunk_pk_d  = pk_new;
        if (hdr_done) begin
          next_ctrl_n = ctrl_pos_q + PW'(hl) + PW'(pk_plus);
          blk_sum_n   = sat_add(blk_sum_q, UW'(unp_plus));
          hdr_idx_d   = 3'd0;
          phase_n     = PH_CTRL;
        end else begin
          hdr_idx_d = idx_inc;
        end
      end
      PH_STOP: ;
      default: ;
    endcase
    if (final_byte_i && (phase_n == PH_HDR)) begin
      stop_n = lzs_pkg::ST_TRUNCATED;
    end
  end

  // Final-byte close of the open block
  assign end_pos = (phase_n == PH_CTRL) ? next_ctrl_n : ctrl_pos_n;
  assign len2    = end_pos - blk_start_q;
  assign emit2   = final_byte_i && !emit1 && !at_limit && (len2 != '0);
  assign emit    = emit1 || emit2;
  assign len_sel = emit1 ? len1 : len2;
  assign run_new = sat_add(run_unp_q, blk_sum_n);
  assign blocks_after = blocks_q + CNTW'(emit);

  assign off_ext = {{OW{1'b0}}, blk_start_q};
  assign len_ext = {{OW{1'b0}}, len_sel};
  assign tot_ext = {{TW{1'b0}}, blocks_after};

  assign has_result_o = emit || final_byte_i;

  always_comb begin
    result_o.block_valid   = emit;
    result_o.pack_offset   = emit ? off_ext[OW-1:0] : '0;
    result_o.pack_length   = emit ? len_ext[OW-1:0] : '0;
    result_o.unp_offset    = emit ? run_unp_q : '0;
    result_o.unpack_length = emit ? blk_sum_n : '0;
    result_o.stream_done   = final_byte_i;
    result_o.block_total   = tot_ext[TW-1:0];
    result_o.unpack_total  = emit ? run_new : run_unp_q;
    result_o.parse_status  = stop_n;
  end

  // Register update; the final byte returns everything to reset
  always_comb begin
    pos_d       = pos_q + PW'(1);
    phase_d     = phase_n;
    next_ctrl_d = next_ctrl_n;
    ctrl_pos_d  = ctrl_pos_n;
    blk_start_d = emit1 ? pos_q : blk_start_q;
    run_unp_d   = emit1 ? run_new : run_unp_q;
    blk_sum_d   = emit1 ? '0 : blk_sum_n;
    blocks_d    = blocks_after;
    stop_d      = stop_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CTRL;
      pos_q       <= '0;
      next_ctrl_q <= '0;
      blk_start_q <= '0;
      ctrl_pos_q  <= '0;
      ctrl_val_q  <= '0;
      hdr_idx_q   <= '0;
      chunk_unp_q <= '0;
      chunk_pk_q  <= '0;
      run_unp_q   <= '0;
      blk_sum_q   <= '0;
      blocks_q    <= '0;
      stop_q      <= lzs_pkg::ST_NORMAL;
    end else if (take_i) begin
      if (final_byte_i) begin
        phase_q     <= PH_CTRL;
        pos_q       <= '0;
        next_ctrl_q <= '0;
        blk_start_q <= '0;
        ctrl_pos_q  <= '0;
        ctrl_val_q  <= '0;
        hdr_idx_q   <= '0;
        chunk_unp_q <= '0;
        chunk_pk_q  <= '0;
        run_unp_q   <= '0;
        blk_sum_q   <= '0;
        blocks_q    <= '0;
        stop_q      <= lzs_pkg::ST_NORMAL;
      end else begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        next_ctrl_q <= next_ctrl_d;
        blk_start_q <= blk_start_d;
        ctrl_pos_q  <= ctrl_pos_d;
        ctrl_val_q  <= ctrl_val_d;
        hdr_idx_q   <= hdr_idx_d;
        chunk_unp_q <= chunk_unp_d;
        chunk_pk_q  <= chunk_pk_d;
        run_unp_q   <= run_unp_d;
        blk_sum_q   <= blk_sum_d;
        blocks_q    <= blocks_d;
        stop_q      <= stop_d;
      end
    end
  end

endmodule
